>>> design/ccm_pkg.sv
// Shared item types and fixed widths for the chunk coordinate hash map.
package ccm_pkg;

  localparam int COORD_W = 16;
  localparam int KEY_W   = 3 * COORD_W;
  localparam int SLOT_W  = 8;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] chunk_x;
    logic signed [COORD_W-1:0] chunk_y;
    logic signed [COORD_W-1:0] chunk_z;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic              allocated;
    logic              table_full;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

endpackage

>>> design/ccm_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ccm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/chunk_coordinate_hash_map_unit.sv
// Top level of the chunk coordinate hash map: chain-walk sequencer and its two memories.
//
// Usage:
//   Input channel: drive in_item and raise start; the item is taken at the edge
//   where start is high and busy is low. operation 0 looks the key up, operation 1
//   looks it up and allocates the next free slot on a miss.
//   Result channel: out_valid strobes for exactly one cycle with out_item; there is
//   no back-pressure, so the result must be captured in that cycle.
//   Walk: the bucket head memory is read first, then each chain entry visited
//   is read in turn through the entry memory read port. An item stops at a hit
//   or a miss (an empty bucket or the end of its chain); its result is registered
//   and busy drops in the same cycle that out_valid shows it, so a new item is
//   taken only after the previous one has reported.
//   Reset: rst_n low clears the free-slot counter and the sequencer; after reset
//   the block sweeps the bucket head memory, one bucket per cycle, through all
//   BUCKETS buckets with busy high before it takes the first item.
//   Allocation writes land in the deciding cycle, before the next item can read,
//   so back-to-back items on the same bucket need no forwarding.
module chunk_coordinate_hash_map_unit #(
  parameter int BUCKETS  = 256,
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ccm_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ccm_pkg::out_item_t out_item
);

  localparam int BW   = $clog2(BUCKETS);
  localparam int SW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = SW + 1;                       // valid bit plus slot index
  localparam int EW   = ccm_pkg::KEY_W + PW;          // key plus link
  localparam int KW   = ccm_pkg::KEY_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_ENTRY
  } state_t;

  state_t state_r, state_nxt;

  logic [KW-1:0] key_r, key_nxt;
  logic          op_r, op_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] nfree_r, nfree_nxt;
  logic [BW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  ccm_pkg::out_item_t out_item_r, out_item_nxt;

  // Memory ports
  logic          head_we;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [PW-1:0] head_wdata, head_rdata;
  logic          entry_we;
  logic [SW-1:0] entry_waddr, entry_raddr;
  logic [EW-1:0] entry_wdata, entry_rdata;

  // Decode of the read data
  logic [15:0]   hash_sum;
  logic [KW-1:0] in_key;
  logic [KW-1:0] entry_key;
  logic [PW-1:0] entry_link;
  logic          hit;
  logic          miss;
  logic          room;
  logic          do_alloc;
  logic [PW-1:0] link_for_new;

  ccm_ram #(
    .WIDTH(PW),
    .DEPTH(BUCKETS)
  ) u_head_ram (
    .clk  (clk),
    .we   (head_we),
    .waddr(head_waddr),
    .wdata(head_wdata),
    .raddr(head_raddr),
    .rdata(head_rdata)
  );

  ccm_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk  (clk),
    .we   (entry_we),
    .waddr(entry_waddr),
    .wdata(entry_wdata),
    .raddr(entry_raddr),
    .rdata(entry_rdata)
  );

  // Hash: two's complement sum of the coordinates, masked to the bucket count.
  assign hash_sum   = in_item.chunk_x + in_item.chunk_y + in_item.chunk_z;
  assign in_key     = {in_item.chunk_z, in_item.chunk_y, in_item.chunk_x};
  assign head_raddr = hash_sum[BW-1:0] & BW'(BUCKETS - 1);

  assign entry_key  = entry_rdata[EW-1 -: KW];
  assign entry_link = entry_rdata[PW-1:0];

  // Entry read address: chain head out of the bucket read, else the link just read.
  assign entry_raddr = (state_r == S_HEAD) ? head_rdata[SW-1:0] : entry_link[SW-1:0];

  assign hit  = (state_r == S_ENTRY) && (entry_key == key_r);
  assign miss = ((state_r == S_HEAD) && !head_rdata[PW-1]) ||
                ((state_r == S_ENTRY) && !hit && !entry_link[PW-1]);
  assign room = nfree_r < CW'(CAPACITY);
  assign do_alloc = miss && op_r && room;

  // New entry links to the old chain head; in the head cycle that is the data read.
  assign link_for_new = (state_r == S_HEAD) ? head_rdata : head_r;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bkt_r;
    head_wdata = {1'b1, nfree_r[SW-1:0]};
    if (state_r == S_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_r;
      head_wdata = '0;
    end else if (do_alloc) begin
      head_we = 1'b1;
    end
  end

  assign entry_we    = do_alloc;
  assign entry_waddr = nfree_r[SW-1:0];
  assign entry_wdata = {key_r, link_for_new};

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    op_nxt        = op_r;
    bkt_nxt       = bkt_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    nfree_nxt     = nfree_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          key_nxt   = in_key;
          op_nxt    = in_item.operation;
          bkt_nxt   = head_raddr;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        head_nxt = head_rdata;
        if (head_rdata[PW-1]) begin
          cur_nxt   = head_rdata[SW-1:0];
          state_nxt = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (!hit && entry_link[PW-1]) begin
          cur_nxt = entry_link[SW-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Close the item on a hit or a miss: report, allocate on an allocating miss with room, go idle.
    if (hit || miss) begin
      state_nxt                = S_IDLE;
      out_valid_nxt            = 1'b1;
      out_item_nxt.found       = hit;
      out_item_nxt.allocated   = do_alloc;
      out_item_nxt.table_full  = miss && op_r && !room;
      out_item_nxt.slot        = hit      ? ccm_pkg::SLOT_W'(cur_r) :
                                 do_alloc ? ccm_pkg::SLOT_W'(nfree_r[SW-1:0]) : '0;
      if (do_alloc) begin
        nfree_nxt = nfree_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      nfree_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nfree_r     <= nfree_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    op_r       <= op_nxt;
    bkt_r      <= bkt_nxt;
    head_r     <= head_nxt;
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // At most one outcome flag per result.
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_item.found, out_item.allocated, out_item.table_full}))
    else $error("more than one outcome flag set");

  // An allocation consumes exactly one slot.
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.allocated) |-> (nfree_r == $past(nfree_r) + 1'b1))
    else $error("allocation did not advance the free-slot counter");

  // Full is only reported once every slot is taken.
  a_full_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.table_full) |-> (nfree_r == CW'(CAPACITY)))
    else $error("table_full reported with free slots left");

  // The sequencer is idle whenever it reports.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

endmodule

>>> sim/chunk_coordinate_hash_map_unit_test.sv
// Self-checking testbench for the chunk coordinate hash map unit.
typedef enum bit {
  OP_LOOKUP   = 1'b0,
  OP_ALLOCATE = 1'b1
} request_op_t;

// Shadow hash table: mirrors bucket heads, chain links and keys, and queues
// the result that each accepted item must produce.
class hash_map_scoreboard_t #(int NBUCKET = 256, int NSLOT = 256);
  bit                        head_valid [NBUCKET];
  int unsigned               head_slot  [NBUCKET];
  bit                        link_valid [NSLOT];
  int unsigned               link_slot  [NSLOT];
  logic [ccm_pkg::KEY_W-1:0] slot_key   [NSLOT];
  int unsigned               slots_used;
  ccm_pkg::out_item_t        pending_results [$];
  int                        errors;
  int                        checked;
  int                        hits;
  int                        allocs;
  int                        fulls;
  int                        misses;

  // Resolve one accepted item against the shadow table and queue its result.
  function void note_request(ccm_pkg::in_item_t item);
    int                        coord_sum;
    int unsigned               bucket;
    int unsigned               cur;
    int unsigned               steps;
    bit                        cur_valid;
    logic [ccm_pkg::KEY_W-1:0] key;
    ccm_pkg::out_item_t        res;
    coord_sum = int'($signed(item.chunk_x)) + int'($signed(item.chunk_y))
              + int'($signed(item.chunk_z));
    bucket    = unsigned'(coord_sum & (NBUCKET - 1));
    key       = {item.chunk_z, item.chunk_y, item.chunk_x};
    res       = '0;
    cur_valid = head_valid[bucket];
    cur       = head_slot[bucket];
    steps     = 0;
    // walk the chain from the head, newest entry first
    while (cur_valid && cur < NSLOT && steps < NSLOT && !res.found) begin
      if (slot_key[cur] == key) begin
        res.found = 1'b1;
        res.slot  = cur[ccm_pkg::SLOT_W-1:0];
      end else begin
        cur_valid = link_valid[cur];
        cur       = link_slot[cur];
        steps++;
      end
    end
    if (!res.found && item.operation == OP_ALLOCATE) begin
      if (slots_used < NSLOT) begin
        slot_key[slots_used]   = key;
        link_valid[slots_used] = head_valid[bucket];
        link_slot[slots_used]  = head_slot[bucket];
        head_valid[bucket]     = 1'b1;
        head_slot[bucket]      = slots_used;
        res.allocated          = 1'b1;
        res.slot               = slots_used[ccm_pkg::SLOT_W-1:0];
        slots_used++;
      end else begin
        res.table_full = 1'b1;
      end
    end
    if (res.found) hits++;
    else if (res.allocated) allocs++;
    else if (res.table_full) fulls++;
    else misses++;
    pending_results.push_back(res);
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // Compare one strobed result with the oldest queued one.
  task check_result(ccm_pkg::out_item_t got);
    ccm_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with none pending: found=%0b alloc=%0b full=%0b slot=%0d",
                                got.found, got.allocated, got.table_full, got.slot));
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (got.found !== want.found)
      report_mismatch($sformatf("result %0d found: got %b want %b", checked, got.found,
                                want.found));
    if (got.allocated !== want.allocated)
      report_mismatch($sformatf("result %0d allocated: got %b want %b", checked,
                                got.allocated, want.allocated));
    if (got.table_full !== want.table_full)
      report_mismatch($sformatf("result %0d table_full: got %b want %b", checked,
                                got.table_full, want.table_full));
    if (got.slot !== want.slot)
      report_mismatch($sformatf("result %0d slot: got %0d want %0d", checked, got.slot,
                                want.slot));
  endtask
endclass

module chunk_coordinate_hash_map_unit_test;

  localparam int BUCKETS  = 256;
  localparam int CAPACITY = 256;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  ccm_pkg::in_item_t  in_item;
  logic               out_valid;
  ccm_pkg::out_item_t out_item;

  hash_map_scoreboard_t #(BUCKETS, CAPACITY) board;

  // every key sent so far, so random traffic can come back to it
  logic [ccm_pkg::KEY_W-1:0] known_keys [$];
  // items left in a stretch sent back to back with no idle cycles
  int                        burst_left;

  chunk_coordinate_hash_map_unit #(
    .BUCKETS  (BUCKETS),
    .CAPACITY (CAPACITY)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: sized for every item walking a full-length chain plus the
  // longest idle gap, several times over.
  initial begin
    #4000000;
    $display("timeout with %0d results still pending", board.pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Results cannot be held off: grab each one in its strobe cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) board.check_result(out_item);
  end

  function automatic ccm_pkg::in_item_t make_item(request_op_t op, logic [15:0] x,
                                                  logic [15:0] y, logic [15:0] z);
    ccm_pkg::in_item_t item;
    item.operation = op;
    item.chunk_x   = x;
    item.chunk_y   = y;
    item.chunk_z   = z;
    return item;
  endfunction

  // Present one item, hold it until the edge that takes it, then idle for a
  // random gap. A zero gap leaves start high so the next item follows at once.
  task automatic issue_request(input ccm_pkg::in_item_t item);
    int gap;
    int roll;
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_request(item);
    known_keys.push_back({item.chunk_z, item.chunk_y, item.chunk_x});
    roll = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (roll < 4) begin
      burst_left = $urandom_range(40, 10);
      gap = 0;
    end else if (roll < 40) begin
      gap = 0;
    end else if (roll < 85) begin
      gap = $urandom_range(3, 1);
    end else if (roll < 97) begin
      gap = $urandom_range(12, 4);
    end else begin
      gap = $urandom_range(60, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int                        n;
    int                        roll;
    int                        target;
    request_op_t               op;
    logic [15:0]               rx;
    logic [15:0]               ry;
    logic [15:0]               rz;
    logic [ccm_pkg::KEY_W-1:0] k;
    board      = new();
    burst_left = 0;
    start     <= 1'b0;
    in_item   <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Lookup on an empty table, then allocate and find again.
    issue_request(make_item(OP_LOOKUP,   16'h0000, 16'h0000, 16'h0000));
    issue_request(make_item(OP_ALLOCATE, 16'h0000, 16'h0000, 16'h0000));
    issue_request(make_item(OP_LOOKUP,   16'h0000, 16'h0000, 16'h0000));
    // allocate on a key already present must only report it found
    issue_request(make_item(OP_ALLOCATE, 16'h0000, 16'h0000, 16'h0000));
    // coordinate extremes: the sum overflows 16 bits in both directions
    issue_request(make_item(OP_ALLOCATE, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    issue_request(make_item(OP_ALLOCATE, 16'h8000, 16'h8000, 16'h8000));
    issue_request(make_item(OP_LOOKUP,   16'h8000, 16'h8000, 16'h8000));
    issue_request(make_item(OP_ALLOCATE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // distinct keys that sum to zero: build a chain on bucket 0
    issue_request(make_item(OP_ALLOCATE, 16'h7FFF, 16'h8000, 16'h0001));
    issue_request(make_item(OP_ALLOCATE, 16'h0001, 16'hFFFF, 16'h0000));
    issue_request(make_item(OP_LOOKUP,   16'h0000, 16'h0000, 16'h0000));
    issue_request(make_item(OP_LOOKUP,   16'h0005, 16'hFFFB, 16'h0000));
    issue_request(make_item(OP_ALLOCATE, 16'h8000, 16'h7FFF, 16'h0001));
    issue_request(make_item(OP_LOOKUP,   16'h7FFF, 16'h8000, 16'h0001));
    // negative sum lands in the top bucket
    issue_request(make_item(OP_ALLOCATE, 16'h0000, 16'h8000, 16'h7FFF));
    issue_request(make_item(OP_LOOKUP,   16'hFFFF, 16'hFFFF, 16'hFFFF));
    // alternating bit patterns in every field
    issue_request(make_item(OP_ALLOCATE, 16'h5555, 16'hAAAA, 16'h0F0F));
    issue_request(make_item(OP_ALLOCATE, 16'hAAAA, 16'h5555, 16'hF0F0));
    issue_request(make_item(OP_LOOKUP,   16'h5555, 16'hAAAA, 16'h0F0F));
    issue_request(make_item(OP_LOOKUP,   16'h0001, 16'h0000, 16'h0000));

    // Random part: revisit old keys, pile fresh keys onto a few hot buckets
    // to grow long chains, and mix in fully random keys. Allocations outnumber
    // the slots, so the pool runs dry partway through.
    n = 0;
    while (n < 600) begin
      roll = $urandom_range(99);
      op   = ($urandom_range(99) < 75) ? OP_ALLOCATE : OP_LOOKUP;
      rx   = 16'($urandom);
      ry   = 16'($urandom);
      rz   = 16'($urandom);
      if (roll < 30 && known_keys.size() > 0) begin
        k  = known_keys[$urandom_range(known_keys.size() - 1)];
        rx = k[15:0];
        ry = k[31:16];
        rz = k[47:32];
      end else if (roll < 65) begin
        case ($urandom_range(3))
          0: target = 0;
          1: target = 1;
          2: target = BUCKETS / 2;
          default: target = BUCKETS - 1;
        endcase
        target = target - int'($signed(rx)) - int'($signed(ry));
        rz     = target[15:0];
      end
      issue_request(make_item(op, rx, ry, rz));
      n++;
    end
    start <= 1'b0;

    // Drain, then linger long enough for any stray result to show up.
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("checked %0d results: %0d hits, %0d allocations, %0d misses, %0d pool-full",
             board.checked, board.hits, board.allocs, board.misses, board.fulls);
    $display("%0d of %0d slots handed out, %0d mismatches", board.slots_used, CAPACITY,
             board.errors);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
